[rtl/gdsi_pkg.sv]
// Package for the grouped descending sorted insert block.
// Holds the word types, status and command codes, and the controller link structs.
// Depends on nothing.
package gdsi_pkg;

  localparam int GroupsDefault = 8;
  localparam int DepthDefault  = 16;
  localparam int IdW           = 16;
  localparam int LevelW        = 12;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_ENTRY   = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        group_code;
    logic [IdW-1:0]    record_id;
    logic [LevelW-1:0] level;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [IdW-1:0]    out_id;
    logic [LevelW-1:0] out_level;
    logic              last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       init_ins;
    logic       init_list;
    logic       shift_step;
    logic       place_above;
    logic       place_zero;
    logic       list_emit;
    logic       load_status;
    logic [2:0] status_code;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_list;
    logic grp_invalid;
    logic cnt_zero;
    logic cnt_full;
    logic idx_zero;
    logic rd_above;
    logic out_free;
    logic list_last;
  } dp_status_t;

endpackage

[rtl/gdsi_ram.sv]
// Generic single write, single read RAM with a registered read port.
// Depends on nothing.
module gdsi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/gdsi_ctrl.sv]
// Controller state machine for the grouped descending sorted insert block.
// Depends on gdsi_pkg.
module gdsi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  gdsi_pkg::dp_status_t st,
  output gdsi_pkg::ctrl_cmd_t  cmd
);
  import gdsi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_PLACE0 = 6'b001000,
    S_LIST   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [2:0] resp_code, resp_code_next;

  assign req_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    resp_code_next = resp_code;
    cmd            = '0;
    cmd.status_code = resp_code;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.grp_invalid) begin
          resp_code_next = ST_INVALID;
          state_next     = S_RESP;
        end else if (st.is_list) begin
          if (st.cnt_zero) begin
            resp_code_next = ST_EMPTY;
            state_next     = S_RESP;
          end else begin
            cmd.init_list = 1'b1;
            state_next    = S_LIST;
          end
        end else if (st.cnt_full) begin
          resp_code_next = ST_FULL;
          state_next     = S_RESP;
        end else if (st.cnt_zero) begin
          cmd.place_zero = 1'b1;
          resp_code_next = ST_OK;
          state_next     = S_RESP;
        end else begin
          cmd.init_ins = 1'b1;
          state_next   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st.rd_above) begin
          cmd.place_above = 1'b1;
          resp_code_next  = ST_OK;
          state_next      = S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
          if (st.idx_zero) begin
            state_next = S_PLACE0;
          end
        end
      end
      S_PLACE0: begin
        cmd.place_zero = 1'b1;
        resp_code_next = ST_OK;
        state_next     = S_RESP;
      end
      S_LIST: begin
        if (st.out_free) begin
          cmd.list_emit = 1'b1;
          if (st.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    resp_code <= resp_code_next;
  end

endmodule

[rtl/gdsi_dp.sv]
// Datapath: input register, group counts, cursor, record RAM and output register.
// Depends on gdsi_pkg and gdsi_ram.
module gdsi_dp #(
  parameter int GROUPS          = gdsi_pkg::GroupsDefault,
  parameter int PER_GROUP_DEPTH = gdsi_pkg::DepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gdsi_pkg::in_word_t   req,
  input  gdsi_pkg::ctrl_cmd_t  cmd,
  output gdsi_pkg::dp_status_t st,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output gdsi_pkg::out_word_t  rsp
);
  import gdsi_pkg::*;

  localparam int Cells = GROUPS * PER_GROUP_DEPTH;
  localparam int AW    = $clog2(Cells);
  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IW    = $clog2(PER_GROUP_DEPTH);
  localparam int CW    = $clog2(PER_GROUP_DEPTH + 1);
  localparam int RW    = IdW + LevelW;

  in_word_t          in_q;
  logic [IW-1:0]     idx, idx_next;
  logic [CW-1:0]     counts [GROUPS];
  logic [GW-1:0]     grp_sel;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     base;
  logic [AW-1:0]     raddr, waddr;
  logic [RW-1:0]     wdata, rdata;
  logic              re, we;
  logic [IdW-1:0]    rd_id;
  logic [LevelW-1:0] rd_level;
  logic              out_free;

  assign grp_sel  = in_q.group_code[GW-1:0];
  assign cnt      = counts[grp_sel];
  assign base     = AW'(grp_sel) * AW'(PER_GROUP_DEPTH);
  assign rd_id    = rdata[RW-1:LevelW];
  assign rd_level = rdata[LevelW-1:0];
  assign out_free = !rsp_valid || !rsp_stall;

  // Status back to the controller.
  always_comb begin
    st.is_list     = (in_q.cmd == CMD_LIST);
    st.grp_invalid = ({1'b0, in_q.group_code} >= 5'(GROUPS));
    st.cnt_zero    = (cnt == '0);
    st.cnt_full    = (cnt == CW'(PER_GROUP_DEPTH));
    st.idx_zero    = (idx == '0);
    st.rd_above    = (rd_level > in_q.level);
    st.out_free    = out_free;
    st.list_last   = ((CW'(idx) + CW'(1)) == cnt);
  end

  // Cursor update and read requests.
  always_comb begin
    idx_next = idx;
    re       = 1'b0;
    if (cmd.init_ins) begin
      idx_next = IW'(cnt - CW'(1));
      re       = 1'b1;
    end else if (cmd.init_list) begin
      idx_next = '0;
      re       = 1'b1;
    end else if (cmd.shift_step) begin
      idx_next = idx - IW'(1);
      re       = 1'b1;
    end else if (cmd.list_emit) begin
      idx_next = idx + IW'(1);
      re       = 1'b1;
    end
    raddr = base + AW'(idx_next);
  end

  // Write requests: move an entry down one cell or place the new record.
  always_comb begin
    we    = cmd.shift_step || cmd.place_above || cmd.place_zero;
    wdata = cmd.shift_step ? rdata : {in_q.record_id, in_q.level};
    waddr = cmd.place_zero ? base : (base + AW'(idx) + AW'(1));
  end

  gdsi_ram #(
    .Width (RW),
    .Depth (Cells)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Input word, cursor and output word registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= req;
    end
    idx <= idx_next;
    if (cmd.list_emit) begin
      rsp <= '{status: ST_ENTRY, out_id: rd_id, out_level: rd_level,
               last: st.list_last};
    end else if (cmd.load_status) begin
      rsp <= '{status: cmd.status_code, out_id: '0, out_level: '0, last: 1'b1};
    end
  end

  // Group counts and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUPS; g++) begin
        counts[g] <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.place_above || cmd.place_zero) begin
        counts[grp_sel] <= cnt + CW'(1);
      end
      if (cmd.list_emit || cmd.load_status) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/grouped_descending_sorted_insert.sv]
// Top level of the grouped descending sorted insert block.
// Depends on gdsi_pkg, gdsi_ctrl and gdsi_dp.
//
// Usage: each request word carries an insert or a list command for one group.
// The block holds GROUPS groups of up to PER_GROUP_DEPTH records, each kept in
// descending level order with newer records ahead of equal levels.
// Request channel: req_valid, req_stall, req. A word is taken when valid is
// high and stall is low; stall stays high until the previous word is fully
// answered, so one command is worked on at a time.
// Response channel: rsp_valid, rsp_stall, rsp, through one output register.
// Status answers and an insert into an empty group are decided in the check
// state and loaded from the response state. An insert into a non-empty group
// walks the group from its tail, moving one record per cycle through the
// single write port of the record RAM, and answers once it reads a record
// above the new level or has moved the head record. A list gives its entries
// from the head of the group, one entry per cycle while the receiver does not
// stall; a stall holds the current word and pauses the walk. The next word can
// be taken in the cycle after the last result is loaded.
// Reset clears every group count and the control state; the RAM holds no
// reset value, and no clearing pass is needed.
module grouped_descending_sorted_insert #(
  parameter int GROUPS          = gdsi_pkg::GroupsDefault,
  parameter int PER_GROUP_DEPTH = gdsi_pkg::DepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  gdsi_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output gdsi_pkg::out_word_t rsp
);
  import gdsi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  gdsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  gdsi_dp #(
    .GROUPS          (GROUPS),
    .PER_GROUP_DEPTH (PER_GROUP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
